// File: hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GCDN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that implies another one on the following clock edge.
`define GCDN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/gcdn_pkg.sv
`default_nettype none

package gcdn_pkg;

  localparam int MaxDims  = 32;
  localparam int MaxRows  = 32;
  localparam int DimW     = 5;
  localparam int RowW     = 5;
  localparam int GenAw    = DimW + RowW;
  localparam int WordW    = 64;
  localparam int DropBits = 11;
  localparam int CntW     = 33;
  localparam int MaxLog2  = 32;
  localparam int CfgW     = 6;
  localparam int CfgIdxW  = 2;
  localparam int InDataW  = 80;
  localparam int OutDataW = 72;

  typedef enum logic [1:0] {
    CmdLoadGen   = 2'd0,
    CmdLoadShift = 2'd1,
    CmdRestart   = 2'd2,
    CmdNext      = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNumDims     = 2'd0,
    CfgLog2Points  = 2'd1,
    CfgShiftEnable = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0]  dim_out;
    logic [WordW-1:0] coordinate;
    logic             last_dim;
  } result_t;

  // Trailing-zero count of a nonzero counter below 2^32.
  function automatic logic [RowW-1:0] trailing_zeros(input logic [MaxLog2-1:0] v);
    logic [RowW-1:0] n;
    n = '0;
    for (int i = MaxLog2 - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = RowW'(i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hdl/gcdn_out_fifo.sv
`default_nettype none

module gcdn_out_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire gcdn_pkg::result_t data_i,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output gcdn_pkg::result_t      data_o,
  output logic [1:0]             count_o
);

  gcdn_pkg::result_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (do_pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/gray_code_digital_net_points.sv
// Channel   Dir  Word layout (lsb first)                         Side band
// s_axis    in   cmd[1:0] dim_sel[6:2] row_sel[11:7] word[75:12]  -
// m_axis    out  dim_out[4:0] coordinate[68:5]                    tlast = last_dim
// cfg       in   cfg_idx_i selects register, cfg_wdata_i value    -
//
// Load commands leave the input ready. A restart or next-point command is accepted,
// then reads each dimension in use once the output buffer has a slot for its result
// and writes it back; the input is ready again after the last write-back.
// Reset sets the counter to one, loads the register defaults and clears the valid
// bits of the shift and accumulator memories; the generator memory is not cleared.
// A two-word output buffer holds results; reads stop while no slot is free for them.
`default_nettype none

module gray_code_digital_net_points (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // cmd, dim_sel, row_sel, load_word, zero pad
  input  wire logic [gcdn_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // dim_out, coordinate, zero pad
  output logic [gcdn_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_we_i,
  input  wire logic [gcdn_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [gcdn_pkg::CfgW-1:0]      cfg_wdata_i
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  // Input word fields.
  gcdn_pkg::cmd_e                    in_cmd;
  logic [gcdn_pkg::DimW-1:0]         in_dim;
  logic [gcdn_pkg::RowW-1:0]         in_row;
  logic [gcdn_pkg::WordW-1:0]        in_word;
  logic                              in_acc;

  assign in_cmd  = gcdn_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign in_dim  = s_axis_tdata[6:2];
  assign in_row  = s_axis_tdata[11:7];
  assign in_word = s_axis_tdata[75:12];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // Configuration.
  logic [gcdn_pkg::CfgW-1:0] num_dims_q, log2_q;
  logic                      shift_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= gcdn_pkg::CfgW'(1);
      log2_q     <= gcdn_pkg::CfgW'(10);
      shift_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (gcdn_pkg::cfg_idx_e'(cfg_idx_i))
        gcdn_pkg::CfgNumDims:     num_dims_q <= cfg_wdata_i;
        gcdn_pkg::CfgLog2Points:  log2_q     <= cfg_wdata_i;
        gcdn_pkg::CfgShiftEnable: shift_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Index of the last dimension in use.
  logic [gcdn_pkg::DimW-1:0] dim_last;
  always_comb begin
    if (num_dims_q == '0) begin
      dim_last = '0;
    end else if (num_dims_q > gcdn_pkg::CfgW'(gcdn_pkg::MaxDims)) begin
      dim_last = gcdn_pkg::DimW'(gcdn_pkg::MaxDims - 1);
    end else begin
      dim_last = gcdn_pkg::DimW'(num_dims_q - gcdn_pkg::CfgW'(1));
    end
  end

  // Sequencer state.
  logic                       state_q, state_d;
  logic [gcdn_pkg::DimW-1:0]  k_q, k_d;
  logic [gcdn_pkg::RowW-1:0]  row_q, row_d;
  logic                       clear_q, clear_d;
  logic [gcdn_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                       infl_q, infl_d;
  logic [gcdn_pkg::DimW-1:0]  k2_q, k2_d;
  logic                       last2_q, last2_d;
  logic [gcdn_pkg::MaxDims-1:0] acc_vld_q, acc_vld_d;
  logic [gcdn_pkg::MaxDims-1:0] sh_vld_q;

  logic [gcdn_pkg::CfgW-1:0]  lp;
  logic                       wrap, start, start_clear, issue, pop;
  logic [1:0]                 fifo_cnt, occ;

  assign lp = (log2_q > gcdn_pkg::CfgW'(gcdn_pkg::MaxLog2))
              ? gcdn_pkg::CfgW'(gcdn_pkg::MaxLog2) : log2_q;
  assign wrap = (cnt_q >> lp) != '0;
  assign start = in_acc && (in_cmd == gcdn_pkg::CmdRestart || in_cmd == gcdn_pkg::CmdNext);
  assign start_clear = (in_cmd == gcdn_pkg::CmdRestart) || wrap;

  assign s_axis_tready = (state_q == StIdle) && !infl_q;

  // A read is issued only when its result has a guaranteed slot in the buffer.
  assign pop   = m_axis_tvalid && m_axis_tready;
  assign occ   = fifo_cnt + {1'b0, infl_q};
  assign issue = (state_q == StRun) && ((occ < 2'd2) || (occ == 2'd2 && pop));

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    row_d     = row_q;
    clear_d   = clear_q;
    cnt_d     = cnt_q;
    acc_vld_d = acc_vld_q;
    infl_d    = issue;
    k2_d      = k_q;
    last2_d   = (k_q == dim_last);
    if (infl_q) begin
      acc_vld_d[k2_q] = 1'b1;
    end
    if (start) begin
      state_d = StRun;
      k_d     = '0;
      row_d   = gcdn_pkg::trailing_zeros(cnt_q[gcdn_pkg::MaxLog2-1:0]);
      clear_d = start_clear;
      if (start_clear) begin
        cnt_d     = gcdn_pkg::CntW'(1);
        acc_vld_d = '0;
      end else begin
        cnt_d = cnt_q + gcdn_pkg::CntW'(1);
      end
    end else if (issue) begin
      if (k_q == dim_last) begin
        state_d = StIdle;
      end else begin
        k_d = k_q + gcdn_pkg::DimW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      k_q       <= '0;
      row_q     <= '0;
      clear_q   <= 1'b0;
      cnt_q     <= gcdn_pkg::CntW'(1);
      infl_q    <= 1'b0;
      k2_q      <= '0;
      last2_q   <= 1'b0;
      acc_vld_q <= '0;
      sh_vld_q  <= '0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      row_q     <= row_d;
      clear_q   <= clear_d;
      cnt_q     <= cnt_d;
      infl_q    <= infl_d;
      k2_q      <= k2_d;
      last2_q   <= last2_d;
      acc_vld_q <= acc_vld_d;
      if (in_acc && in_cmd == gcdn_pkg::CmdLoadShift) begin
        sh_vld_q[in_dim] <= 1'b1;
      end
    end
  end

  // Memories: generator words, shift words and running point words.
  logic [gcdn_pkg::WordW-1:0] gen_mem [gcdn_pkg::MaxDims * gcdn_pkg::MaxRows];
  logic [gcdn_pkg::WordW-1:0] sh_mem  [gcdn_pkg::MaxDims];
  logic [gcdn_pkg::WordW-1:0] acc_mem [gcdn_pkg::MaxDims];
  logic [gcdn_pkg::WordW-1:0] gen_rd_q, sh_rd_q, acc_rd_q;
  logic [gcdn_pkg::WordW-1:0] acc_new, sh_eff, shifted;

  always_ff @(posedge clk_i) begin
    if (in_acc && in_cmd == gcdn_pkg::CmdLoadGen) begin
      gen_mem[{in_dim, in_row}] <= in_word;
    end
    if (issue) begin
      gen_rd_q <= gen_mem[{k_q, row_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_cmd == gcdn_pkg::CmdLoadShift) begin
      sh_mem[in_dim] <= in_word;
    end
    if (issue) begin
      sh_rd_q <= sh_mem[k_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (infl_q) begin
      acc_mem[k2_q] <= acc_new;
    end
    if (issue) begin
      acc_rd_q <= acc_mem[k_q];
    end
  end

  // A restart or wrap leaves every running word cleared and adds no row.
  assign acc_new = (acc_vld_q[k2_q] ? acc_rd_q : '0) ^ (clear_q ? '0 : gen_rd_q);
  assign sh_eff  = (shift_en_q && sh_vld_q[k2_q]) ? sh_rd_q : '0;
  assign shifted = acc_new ^ sh_eff;

  gcdn_pkg::result_t res, out_res;
  always_comb begin
    res.dim_out    = k2_q;
    // Low bits are dropped, so adding one only sets the lowest bit.
    res.coordinate = {shifted[gcdn_pkg::WordW-1:gcdn_pkg::DropBits],
                      {(gcdn_pkg::DropBits - 1){1'b0}}, 1'b1};
    res.last_dim   = last2_q;
  end

  gcdn_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (infl_q),
    .data_i  (res),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_res),
    .count_o (fifo_cnt)
  );

  assign m_axis_tdata = {3'b000, out_res.coordinate, out_res.dim_out};
  assign m_axis_tlast = out_res.last_dim;

endmodule

`default_nettype wire

// File: hdl/gcdn_checker.sv
`default_nettype none
`include "assert_macros.svh"

module gcdn_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [gcdn_pkg::InDataW-1:0]   s_axis_tdata,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [gcdn_pkg::OutDataW-1:0]  m_axis_tdata,
  input wire logic                           m_axis_tlast
);

  logic                          out_acc, in_acc, in_start, in_load, out_stall, dim_ok;
  logic                          prev_last_q;
  logic [gcdn_pkg::DimW-1:0]     prev_dim_q, out_dim;
  logic [gcdn_pkg::OutDataW+1:0] out_word;

  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tvalid, m_axis_tlast, m_axis_tdata};
  assign out_dim   = m_axis_tdata[gcdn_pkg::DimW-1:0];
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_start  = in_acc && (s_axis_tdata[1:0] == gcdn_pkg::CmdRestart ||
                                s_axis_tdata[1:0] == gcdn_pkg::CmdNext);
  assign in_load   = in_acc && (s_axis_tdata[1:0] == gcdn_pkg::CmdLoadGen ||
                                s_axis_tdata[1:0] == gcdn_pkg::CmdLoadShift);
  assign dim_ok    = prev_last_q ? (out_dim == '0)
                                 : (out_dim == prev_dim_q + gcdn_pkg::DimW'(1));

  // Tracks where the previous delivered word sat within its point.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_last_q <= 1'b1;
      prev_dim_q  <= '0;
    end else if (out_acc) begin
      prev_last_q <= m_axis_tlast;
      prev_dim_q  <= out_dim;
    end
  end

  `GCDN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, $stable(out_word), "word changed")
  `GCDN_ASSERT(a_dim_order, clk_i, rst_ni, !out_acc || dim_ok, "dimension out of order")
  `GCDN_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, in_start, !s_axis_tready, "input not busy")
  `GCDN_ASSERT_NEXT(a_load_free, clk_i, rst_ni, in_load, s_axis_tready, "load stalled input")

endmodule

bind gray_code_digital_net_points gcdn_checker u_gcdn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import gcdn_pkg::*;

  localparam int        HalfPeriod  = 6;
  localparam int        ResetCycles = 6;
  // A point costs its accept, a read per dimension and the drain of the output buffer.
  localparam int        SettleCycles = 40;
  localparam int        HoldCycles   = 400;
  localparam int        RandomWords  = 55;
  localparam longint    RunLimitNs   = 64'd15_000_000;
  localparam bit [63:0] AllOnes      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam bit [63:0] TopCoord     = 64'hFFFF_FFFF_FFFF_F801;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // cmd, dim_sel, row_sel, load_word, zero pad
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // dim_out, coordinate, zero pad
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;

  gray_code_digital_net_points DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #(HalfPeriod) clk_i = ~clk_i;
  end

  // Shadow copy of the point walk.
  logic [WordW-1:0] gen_words   [MaxDims][MaxRows];
  bit               gen_written [MaxDims][MaxRows];
  logic [WordW-1:0] shift_words [MaxDims];
  logic [WordW-1:0] run_words   [MaxDims];
  logic [CntW-1:0]  pt_index;
  logic [CfgW-1:0]  reg_num_dims;
  logic [CfgW-1:0]  reg_log2;
  logic             reg_shift_en;

  result_t expected_coords [$];
  result_t fresh_coords [$];
  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit rx_hold_req = 1'b0;

  function automatic int unsigned dims_used();
    if (reg_num_dims == 0) return 1;
    if (reg_num_dims > MaxDims) return MaxDims;
    return 32'(reg_num_dims);
  endfunction

  function automatic int unsigned low_zero_run(logic [CntW-1:0] v);
    int unsigned n;
    n = 0;
    while (n < CntW && !v[n]) n++;
    return n;
  endfunction

  function automatic int unsigned period_log2();
    return (reg_log2 > MaxLog2) ? MaxLog2 : 32'(reg_log2);
  endfunction

  function automatic void restart_walk();
    foreach (run_words[i]) run_words[i] = '0;
    pt_index = 1;
  endfunction

  function automatic void queue_point();
    int unsigned n;
    logic [WordW-1:0] sh;
    logic [WordW-1:0] w;
    result_t res;
    n = dims_used();
    for (int unsigned i = 0; i < n; i++) begin
      sh = reg_shift_en ? shift_words[i] : '0;
      w = ((run_words[i] ^ sh) >> DropBits) << DropBits;
      res.dim_out = DimW'(i);
      res.coordinate = w + 1;
      res.last_dim = (i + 1 == n);
      fresh_coords.push_back(res);
    end
  endfunction

  function automatic void advance_net_point(cmd_e c, logic [DimW-1:0] d, logic [RowW-1:0] r,
                                            logic [WordW-1:0] w);
    int unsigned row_idx;
    fresh_coords.delete();
    case (c)
      CmdLoadGen: begin
        gen_words[d][r] = w;
        gen_written[d][r] = 1'b1;
      end
      CmdLoadShift: begin
        shift_words[d] = w;
      end
      CmdRestart: begin
        restart_walk();
        queue_point();
      end
      default: begin
        if (pt_index >= (CntW'(1) << period_log2())) begin
          restart_walk();
        end else begin
          row_idx = low_zero_run(pt_index);
          if (row_idx < MaxRows) begin
            for (int unsigned i = 0; i < dims_used(); i++) begin
              run_words[i] ^= gen_words[i][row_idx];
            end
          end
          pt_index = pt_index + 1;
        end
        queue_point();
      end
    endcase
  endfunction

  // Drives one word, waits for it to be taken and records what it must produce.
  task automatic send_item(cmd_e c, logic [DimW-1:0] d, logic [RowW-1:0] r,
                           logic [WordW-1:0] w, bit typed, logic [WordW-1:0] typed_coord);
    int unsigned gap;
    result_t res;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {4'b0, w, r, d, c};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    advance_net_point(c, d, r, w);
    if (typed) begin
      res.dim_out = '0;
      res.coordinate = typed_coord;
      res.last_dim = 1'b1;
      expected_coords.push_back(res);
    end else begin
      foreach (fresh_coords[i]) expected_coords.push_back(fresh_coords[i]);
    end
  endtask

  task automatic send_random(cmd_e c);
    send_item(c, DimW'($urandom_range(0, 31)), RowW'($urandom_range(0, 31)),
              {$urandom, $urandom}, 1'b0, '0);
  endtask

  // Loads any generator word that the coming next-point word would read before it was written.
  task automatic send_next();
    int unsigned row_idx;
    if (pt_index < (CntW'(1) << period_log2())) begin
      row_idx = low_zero_run(pt_index);
      if (row_idx < MaxRows) begin
        for (int unsigned i = 0; i < dims_used(); i++) begin
          if (!gen_written[i][row_idx]) begin
            send_item(CmdLoadGen, DimW'(i), RowW'(row_idx), {$urandom, $urandom}, 1'b0, '0);
          end
        end
      end
    end
    send_random(CmdNext);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_coords.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgNumDims:    reg_num_dims = value;
      CfgLog2Points: reg_log2 = value;
      default:       reg_shift_en = value[0];
    endcase
  endtask

  typedef struct packed {
    logic             is_cfg;
    cfg_idx_e         idx;
    logic [CfgW-1:0]  reg_val;
    cmd_e             cmd;
    logic [DimW-1:0]  dim;
    logic [RowW-1:0]  row;
    logic [WordW-1:0] word;
    logic             typed;
    logic [WordW-1:0] coord;
  } step_t;

  // Starts from the reset settings: one dimension, period 2^10, shift off.
  // is_cfg, reg, value, cmd, dim, row, word, typed, coordinate
  step_t directed_plan [24] = '{
    '{1'b0, CfgNumDims, 6'd0, CmdRestart, 5'd0, 5'd0, 64'd0, 1'b1, 64'd1},
    '{1'b0, CfgNumDims, 6'd0, CmdLoadGen, 5'd0, 5'd0, AllOnes, 1'b0, 64'd0},
    '{1'b0, CfgNumDims, 6'd0, CmdLoadGen, 5'd0, 5'd1, 64'h7FF, 1'b0, 64'd0},
    '{1'b0, CfgNumDims, 6'd0, CmdLoadShift, 5'd0, 5'd0, AllOnes, 1'b0, 64'd0},
    '{1'b0, CfgNumDims, 6'd0, CmdNext, 5'd0, 5'd0, 64'd0, 1'b1, TopCoord},
    // Row one only touches the dropped low bits.
    '{1'b0, CfgNumDims, 6'd0, CmdNext, 5'd31, 5'd31, AllOnes, 1'b1, TopCoord},
    '{1'b0, CfgNumDims, 6'd0, CmdLoadGen, 5'd31, 5'd31, 64'h5A3C_96E1_0F87_D2B4, 1'b0, 64'd0},
    '{1'b0, CfgNumDims, 6'd0, CmdLoadGen, 5'd0, 5'd2, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
    '{1'b0, CfgNumDims, 6'd0, CmdNext, 5'd0, 5'd0, 64'd0, 1'b1, 64'd1},
    '{1'b0, CfgNumDims, 6'd0, CmdNext, 5'd0, 5'd0, 64'd0, 1'b1, 64'h8000_0000_0000_0001},
    '{1'b0, CfgNumDims, 6'd0, CmdLoadShift, 5'd31, 5'd0, 64'hC3A5_1E69_B4D2_0F78, 1'b0, 64'd0},
    '{1'b0, CfgNumDims, 6'd0, CmdRestart, 5'd0, 5'd0, 64'd0, 1'b1, 64'd1},
    '{1'b1, CfgShiftEnable, 6'd1, CmdNext, 5'd0, 5'd0, 64'd0, 1'b0, 64'd0},
    '{1'b0, CfgNumDims, 6'd0, CmdRestart, 5'd0, 5'd0, 64'd0, 1'b1, TopCoord},
    '{1'b1, CfgLog2Points, 6'd1, CmdNext, 5'd0, 5'd0, 64'd0, 1'b0, 64'd0},
    '{1'b0, CfgNumDims, 6'd0, CmdNext, 5'd0, 5'd0, 64'd0, 1'b1, 64'd1},
    // The period of two is used up, so this one wraps to the zero point.
    '{1'b0, CfgNumDims, 6'd0, CmdNext, 5'd0, 5'd0, 64'd0, 1'b1, TopCoord},
    '{1'b1, CfgLog2Points, 6'd0, CmdNext, 5'd0, 5'd0, 64'd0, 1'b0, 64'd0},
    '{1'b0, CfgNumDims, 6'd0, CmdNext, 5'd0, 5'd0, 64'd0, 1'b1, TopCoord},
    '{1'b1, CfgLog2Points, 6'd63, CmdNext, 5'd0, 5'd0, 64'd0, 1'b0, 64'd0},
    '{1'b1, CfgNumDims, 6'd0, CmdNext, 5'd0, 5'd0, 64'd0, 1'b0, 64'd0},
    '{1'b0, CfgNumDims, 6'd0, CmdNext, 5'd0, 5'd0, 64'd0, 1'b1, 64'd1},
    '{1'b1, CfgNumDims, 6'd63, CmdNext, 5'd0, 5'd0, 64'd0, 1'b0, 64'd0},
    '{1'b0, CfgNumDims, 6'd0, CmdRestart, 5'd0, 5'd0, 64'd0, 1'b0, 64'd0}
  };

  initial begin : rx_side
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = HoldCycles;
      end else begin
        stall = rx_idle ? $urandom_range(0, 16) : 0;
      end
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin : coord_check
    result_t want;
    logic [DimW-1:0] got_dim;
    logic [WordW-1:0] got_coord;
    got_dim = m_axis_tdata[DimW-1:0];
    got_coord = m_axis_tdata[DimW +: WordW];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_coords.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word dim %0d coordinate %h last %b", $time, got_dim,
                 got_coord, m_axis_tlast);
      end else begin
        want = expected_coords.pop_front();
        if (got_dim !== want.dim_out) begin
          mismatch_count++;
          $display("%0t: dim_out expected %0d actual %0d", $time, want.dim_out, got_dim);
        end
        if (got_coord !== want.coordinate) begin
          mismatch_count++;
          $display("%0t: coordinate of dim %0d expected %h actual %h", $time, want.dim_out,
                   want.coordinate, got_coord);
        end
        if (m_axis_tlast !== want.last_dim) begin
          mismatch_count++;
          $display("%0t: last_dim of dim %0d expected %b actual %b", $time, want.dim_out,
                   want.last_dim, m_axis_tlast);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned first_random;
    int unsigned pick;
    logic [CfgW-1:0] nd;
    logic [CfgW-1:0] lp;
    foreach (shift_words[i]) shift_words[i] = '0;
    foreach (gen_written[i, j]) gen_written[i][j] = 1'b0;
    restart_walk();
    reg_num_dims = 1;
    reg_log2 = 10;
    reg_shift_en = 1'b0;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_plan[k]) begin
      if (directed_plan[k].is_cfg) begin
        drain();
        write_reg(directed_plan[k].idx, directed_plan[k].reg_val);
      end else begin
        send_item(directed_plan[k].cmd, directed_plan[k].dim, directed_plan[k].row,
                  directed_plan[k].word, directed_plan[k].typed, directed_plan[k].coord);
      end
    end

    // Hold the output back while full points keep coming, so the input stalls.
    drain();
    write_reg(CfgNumDims, 6'd8);
    write_reg(CfgLog2Points, 6'd32);
    tx_idle = 1'b0;
    rx_hold_req = 1'b1;
    send_random(CmdRestart);
    repeat (5) send_next();
    drain();
    tx_idle = 1'b1;

    first_random = words_sent;
    while (words_sent - first_random < RandomWords) begin
      drain();
      case ($urandom_range(0, 7))
        0:       nd = 0;
        1:       nd = 63;
        2:       nd = 32;
        default: nd = CfgW'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
        0:       lp = 0;
        1:       lp = 1;
        2:       lp = 32;
        3:       lp = 63;
        default: lp = CfgW'($urandom_range(2, 5));
      endcase
      write_reg(CfgNumDims, nd);
      write_reg(CfgLog2Points, lp);
      write_reg(CfgShiftEnable, CfgW'($urandom_range(0, 1)));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) send_random(CmdRestart);
      repeat ($urandom_range(4, 14)) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) send_next();
        else if (pick < 8) send_random(CmdLoadGen);
        else if (pick == 8) send_random(CmdLoadShift);
        else send_random(CmdRestart);
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin : run_limit
    #(RunLimitNs);
    $display("tb: done, errors");
    $finish;
  end

endmodule
